@@ sv/hbmpr_pkg.sv @@
`default_nettype none

package hbmpr_pkg;

    localparam int VIDEO_HALFWORDS = 65536;
    localparam int VRAM_AW         = $clog2(VIDEO_HALFWORDS);
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int MAX_MAP_DIM     = 1024;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 2;
    localparam int OUT_PW      = $clog2(OUT_DEPTH);
    localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

    // bitmap frame offsets, in bytes and in halfwords
    localparam logic [17:0] FRAME_BYTE_OFS = 18'h0A000;
    localparam logic [17:0] FRAME_HALF_OFS = FRAME_BYTE_OFS >> 1;

    localparam logic [2:0] MODE_TEXT  = 3'd0;
    localparam logic [2:0] MODE_MIXED = 3'd1;
    localparam logic [2:0] MODE_ROT   = 3'd2;
    localparam logic [2:0] MODE_BMP16 = 3'd3;
    localparam logic [2:0] MODE_BMP8  = 3'd4;

    localparam logic [1:0] LAYER_ROT = 2'd2;

    typedef enum logic [1:0] {
        CMD_VWRITE = 2'd0,
        CMD_PWRITE = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_DISPLAY_MODE = 2'd0,
        REG_LAYER        = 2'd1,
        REG_BG_CONTROL   = 2'd2,
        REG_FRAME_SELECT = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        K_VWRITE  = 3'd0,
        K_PWRITE  = 3'd1,
        K_TEXT    = 3'd2,
        K_ROT     = 3'd3,
        K_BMP16   = 3'd4,
        K_BMP8    = 3'd5,
        K_OUTSIDE = 3'd6
    } kind_t;

    // classified word handed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [15:0] addr_a;     // halfword index for the first read, or write address
        logic [15:0] wdata;
        logic [16:0] byte_addr;  // map byte or paletted bitmap byte
        logic [2:0]  tx;
        logic [2:0]  ty;
        logic [1:0]  cb;
        logic        deep;       // 256-colour tiles
    } work_t;

    typedef struct packed {
        kind_t       kind;
        logic        byte_hi;
        logic        nib_hi;
        logic        text4;
        logic [3:0]  bank;
        logic [15:0] color;      // bitmap colour or palette write data
        logic [7:0]  pal_waddr;
    } mid_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] color;
    } tail_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       outside;
    } res_t;

    function automatic logic is_render(kind_t k);
        logic r;
        case (k) inside
            K_TEXT, K_ROT, K_BMP16, K_BMP8, K_OUTSIDE: r = 1'b1;
            default:                                   r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/handheld_bg_map_pixel_renderer_top.sv @@
`default_nettype none

// Background map pixel renderer. Words pushed in either write a video memory
// halfword, write a background palette entry, or ask for the colour of one map
// pixel; only render words produce a result, in order, on the pop side. The
// front decodes each word against the configuration registers (mode, layer,
// layer control, frame) and computes the first memory address; a two-entry
// queue feeds a back pipeline that does the map read, the tile/bitmap byte
// read and the palette read, one per stage, then converts to 8-bit RGB. One
// word is accepted per cycle unless the queue is full; a render result
// passes the queue, the stages of the dependent memory reads and the
// result queue. Writes take effect for every later word. Change configuration
// only while no result is pending and the pipe has drained.
module handheld_bg_map_pixel_renderer_top
    import hbmpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] write_address,
    input  wire logic [15:0] write_data,
    input  wire logic [9:0]  pixel_x,
    input  wire logic [9:0]  pixel_y,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             outside_map
);

    logic  take;
    logic  enq;
    work_t item;
    logic  head_valid;
    work_t head;
    logic  deq;

    assign take = push && !full;

    hbmpr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .take          (take),
        .command       (command),
        .write_address (write_address),
        .write_data    (write_data),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .enq           (enq),
        .item          (item)
    );

    hbmpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq        (enq),
        .enq_item   (item),
        .full       (full),
        .deq        (deq),
        .head_valid (head_valid),
        .head       (head)
    );

    hbmpr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .deq         (deq),
        .pop         (pop),
        .empty       (empty),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .outside_map (outside_map)
    );

endmodule

`default_nettype wire

@@ sv/hbmpr_front.sv @@
`default_nettype none

module hbmpr_front
    import hbmpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        take,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] write_address,
    input  wire logic [15:0] write_data,
    input  wire logic [9:0]  pixel_x,
    input  wire logic [9:0]  pixel_y,
    output logic             enq,
    output work_t            item
);

    logic [2:0]  mode_reg;
    logic [1:0]  layer_reg;
    logic [15:0] bgc_reg;
    logic        frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TEXT;
            layer_reg <= 2'd0;
            bgc_reg   <= 16'd0;
            frame_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DISPLAY_MODE: mode_reg  <= cfg_data[2:0];
                REG_LAYER:        layer_reg <= cfg_data[1:0];
                REG_BG_CONTROL:   bgc_reg   <= cfg_data;
                REG_FRAME_SELECT: frame_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic        map_out;
    logic        text_out;
    logic [15:0] text_map;
    logic        rot_sel;
    logic        rot_out;
    logic [10:0] rot_lim;
    logic [16:0] rot_map;
    logic [17:0] row240;
    logic [17:0] row160;
    logic [17:0] bmp8_sum;
    logic [17:0] small_sum;
    kind_t       map_kind;

    always_comb
    begin
        map_out = ({1'b0, pixel_x} >= 11'(MAX_MAP_DIM)) || ({1'b0, pixel_y} >= 11'(MAX_MAP_DIM));

        // text map: 256 or 512 per side, screen blocks of 0x400 halfwords
        text_out = (bgc_reg[14] ? pixel_x[9] : (|pixel_x[9:8]))
                || (bgc_reg[15] ? pixel_y[9] : (|pixel_y[9:8]));
        text_map = {1'b0, bgc_reg[12:8], 10'b0}
                 + (pixel_y[8] ? (bgc_reg[14] ? 16'h0800 : 16'h0400) : 16'h0000)
                 + (pixel_x[8] ? 16'h0400 : 16'h0000)
                 + {6'b0, pixel_y[7:3], 5'b0}
                 + {11'b0, pixel_x[7:3]};

        // rotation map: 128 << size per side, one byte per tile number
        rot_lim = 11'd128 << bgc_reg[15:14];
        rot_out = ({1'b0, pixel_x} >= rot_lim) || ({1'b0, pixel_y} >= rot_lim);
        rot_map = {1'b0, bgc_reg[12:8], 11'b0}
                + 17'(pixel_x[9:3])
                + (17'(pixel_y[9:3]) << (3'd4 + {1'b0, bgc_reg[15:14]}));

        row240    = ({8'b0, pixel_y} << 8) - ({8'b0, pixel_y} << 4);
        row160    = ({8'b0, pixel_y} << 7) + ({8'b0, pixel_y} << 5);
        bmp8_sum  = row240 + 18'(pixel_x) + (frame_reg ? FRAME_BYTE_OFS : 18'd0);
        small_sum = row160 + 18'(pixel_x) + (frame_reg ? FRAME_HALF_OFS : 18'd0);

        rot_sel = (mode_reg == MODE_ROT) || ((mode_reg == MODE_MIXED) && (layer_reg == LAYER_ROT));

        item           = '0;
        item.kind      = K_OUTSIDE;
        item.wdata     = write_data;
        item.tx        = pixel_x[2:0];
        item.ty        = pixel_y[2:0];
        item.cb        = bgc_reg[3:2];
        item.deep      = bgc_reg[7];
        map_kind       = K_OUTSIDE;

        unique case (mode_reg) inside
            MODE_TEXT, MODE_MIXED, MODE_ROT:
            begin
                if (rot_sel)
                begin
                    map_kind       = rot_out ? K_OUTSIDE : K_ROT;
                    item.byte_addr = rot_map;
                    item.addr_a    = rot_map[16:1];
                end
                else
                begin
                    map_kind    = text_out ? K_OUTSIDE : K_TEXT;
                    item.addr_a = text_map;
                end
            end
            MODE_BMP16:
            begin
                map_kind    = ((pixel_x >= 10'd240) || (pixel_y >= 10'd160)) ? K_OUTSIDE : K_BMP16;
                item.addr_a = 16'(row240 + 18'(pixel_x));
            end
            MODE_BMP8:
            begin
                map_kind       = ((pixel_x >= 10'd240) || (pixel_y >= 10'd160)) ? K_OUTSIDE : K_BMP8;
                item.byte_addr = bmp8_sum[16:0];
            end
            default:
            begin
                map_kind    = ((pixel_x >= 10'd160) || (pixel_y >= 10'd128)) ? K_OUTSIDE : K_BMP16;
                item.addr_a = small_sum[15:0];
            end
        endcase

        enq = take;
        unique case (cmd_t'(command))
            CMD_VWRITE:
            begin
                item.kind   = K_VWRITE;
                item.addr_a = write_address;
            end
            CMD_PWRITE:
            begin
                item.kind   = K_PWRITE;
                item.addr_a = write_address;
            end
            CMD_RENDER: item.kind = map_out ? K_OUTSIDE : map_kind;
            default:    enq = 1'b0;    // drop unused command
        endcase
    end

endmodule

`default_nettype wire

@@ sv/hbmpr_queue.sv @@
`default_nettype none

module hbmpr_queue
    import hbmpr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  enq,
    input  work_t      enq_item,
    output logic       full,
    input  wire logic  deq,
    output logic       head_valid,
    output work_t      head
);

    work_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]  wptr_reg;
    logic [QUEUE_PW-1:0]  rptr_reg;
    logic [QUEUE_CW-1:0]  cnt_reg;
    logic [QUEUE_CW-1:0]  cnt_next;

    assign full       = (cnt_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (enq && !deq)
            cnt_next = cnt_reg + 1'b1;
        else if (!enq && deq)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (enq)
                wptr_reg <= (wptr_reg == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (deq)
                rptr_reg <= (rptr_reg == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            entry_reg[wptr_reg] <= enq_item;
    end

endmodule

`default_nettype wire

@@ sv/hbmpr_back.sv @@
`default_nettype none

module hbmpr_back
    import hbmpr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  head_valid,
    input  work_t      head,
    output logic       deq,
    input  wire logic  pop,
    output logic       empty,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       outside_map
);

    logic [15:0] vram [VIDEO_HALFWORDS];
    logic [15:0] pal  [PALETTE_ENTRIES];

    logic        adv;

    logic        st1_valid_reg;
    work_t       st1_reg;
    logic [15:0] vram_a_reg;
    logic        vram_a_ok_reg;

    logic        st2_valid_reg;
    mid_t        st2_reg;
    mid_t        st2_next;
    logic [15:0] vram_b_reg;
    logic        vram_b_ok_reg;

    logic        st3_valid_reg;
    tail_t       st3_reg;
    logic [15:0] pal_q_reg;

    res_t                out_mem_reg [OUT_DEPTH];
    logic [OUT_PW-1:0]   out_wptr_reg;
    logic [OUT_PW-1:0]   out_rptr_reg;
    logic [OUT_CW-1:0]   out_cnt_reg;

    logic        res_push;
    logic        res_pop;
    res_t        res;
    res_t        out_head;

    // -------- stage 1: tile data address
    logic [15:0] d1;
    logic [9:0]  tile;
    logic [2:0]  txf;
    logic [2:0]  tyf;
    logic [7:0]  rot_tile;
    logic [17:0] cbase;
    logic [17:0] b_sum;
    logic [16:0] b_addr;
    logic [15:0] b_idx;
    logic        a_ok;
    logic        b_ok;

    always_comb
    begin
        d1       = vram_a_ok_reg ? vram_a_reg : 16'd0;
        tile     = d1[9:0];
        txf      = st1_reg.tx ^ {3{d1[10]}};
        tyf      = st1_reg.ty ^ {3{d1[11]}};
        rot_tile = st1_reg.byte_addr[0] ? d1[15:8] : d1[7:0];
        cbase    = {2'b0, st1_reg.cb, 14'b0};

        case (st1_reg.kind)
            K_TEXT:
            begin
                if (st1_reg.deep)
                    b_sum = cbase + (18'(tile) << 6) + (18'(tyf) << 3) + 18'(txf);
                else
                    b_sum = cbase + (18'(tile) << 5) + (18'(tyf) << 2) + 18'(txf[2:1]);
            end
            K_ROT:   b_sum = cbase + (18'(rot_tile) << 6) + (18'(st1_reg.ty) << 3)
                           + 18'(st1_reg.tx);
            default: b_sum = 18'(st1_reg.byte_addr);
        endcase

        // byte addresses wrap at 128 KiB
        b_addr = b_sum[16:0];
        b_idx  = b_addr[16:1];

        st2_next.kind      = st1_reg.kind;
        st2_next.byte_hi   = b_addr[0];
        st2_next.nib_hi    = txf[0];
        st2_next.text4     = (st1_reg.kind == K_TEXT) && !st1_reg.deep;
        st2_next.bank      = d1[15:12];
        st2_next.color     = (st1_reg.kind == K_PWRITE) ? st1_reg.wdata : d1;
        st2_next.pal_waddr = st1_reg.addr_a[7:0];

        a_ok = ({1'b0, head.addr_a} < 17'(VIDEO_HALFWORDS));
        b_ok = ({1'b0, b_idx} < 17'(VIDEO_HALFWORDS));
    end

    // -------- stage 2: palette index
    logic [15:0]       d2;
    logic [7:0]        pbyte;
    logic [PAL_AW-1:0] pidx;

    always_comb
    begin
        d2    = vram_b_ok_reg ? vram_b_reg : 16'd0;
        pbyte = st2_reg.byte_hi ? d2[15:8] : d2[7:0];
        if (st2_reg.text4)
            pidx = PAL_AW'({st2_reg.bank, (st2_reg.nib_hi ? pbyte[7:4] : pbyte[3:0])});
        else
            pidx = PAL_AW'(pbyte);
    end

    // -------- stage 3: colour out
    logic [15:0] col;

    always_comb
    begin
        col = (st3_reg.kind == K_BMP16) ? st3_reg.color : pal_q_reg;
        if (st3_reg.kind == K_OUTSIDE)
        begin
            res.red     = 8'd0;
            res.green   = 8'd0;
            res.blue    = 8'd0;
            res.outside = 1'b1;
        end
        else
        begin
            res.red     = {col[4:0], 3'b0};
            res.green   = {col[9:5], 3'b0};
            res.blue    = {col[14:10], 3'b0};
            res.outside = 1'b0;
        end
    end

    // whole pipe holds while a finished pixel has no room downstream
    assign adv      = !(st3_valid_reg && is_render(st3_reg.kind))
                   || (out_cnt_reg < OUT_CW'(OUT_DEPTH));
    assign deq      = adv && head_valid;
    assign res_push = adv && st3_valid_reg && is_render(st3_reg.kind);
    assign res_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            st1_valid_reg <= head_valid;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_reg       <= head;
            st2_reg       <= st2_next;
            st3_reg.kind  <= st2_reg.kind;
            st3_reg.color <= st2_reg.color;
        end
    end

    // video memory: write beside the first read, so older words read old data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vram_a_reg    <= vram[head.addr_a[VRAM_AW-1:0]];
            vram_a_ok_reg <= a_ok;
            vram_b_reg    <= vram[b_idx[VRAM_AW-1:0]];
            vram_b_ok_reg <= b_ok;
            if (deq && (head.kind == K_VWRITE) && a_ok)
                vram[head.addr_a[VRAM_AW-1:0]] <= head.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pal_q_reg <= pal[pidx];
            if (st2_valid_reg && (st2_reg.kind == K_PWRITE))
                pal[st2_reg.pal_waddr[PAL_AW-1:0]] <= st2_reg.color;
        end
    end

    // -------- result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wptr_reg <= '0;
            out_rptr_reg <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            if (res_push && !res_pop)
                out_cnt_reg <= out_cnt_reg + 1'b1;
            else if (!res_push && res_pop)
                out_cnt_reg <= out_cnt_reg - 1'b1;
            if (res_push)
                out_wptr_reg <= (out_wptr_reg == OUT_PW'(OUT_DEPTH - 1)) ? '0 : out_wptr_reg + 1'b1;
            if (res_pop)
                out_rptr_reg <= (out_rptr_reg == OUT_PW'(OUT_DEPTH - 1)) ? '0 : out_rptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            out_mem_reg[out_wptr_reg] <= res;
    end

    assign out_head    = out_mem_reg[out_rptr_reg];
    assign empty       = (out_cnt_reg == '0);
    assign red         = out_head.red;
    assign green       = out_head.green;
    assign blue        = out_head.blue;
    assign outside_map = out_head.outside;

    a_out_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= OUT_CW'(OUT_DEPTH))
        else $error("result queue overfilled");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (st3_valid_reg && !adv) |=> (st3_valid_reg && $stable(st3_reg.kind)))
        else $error("last stage changed during stall");

    a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && outside_map) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
        else $error("outside pixel carries colour");

    a_stage1_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(st1_valid_reg) |-> $past(deq))
        else $error("stage 1 filled without a dequeue");

endmodule

`default_nettype wire
